>>> rtl/utf8_to_vfd_codepage_core_assert.svh
// Assertion macros shared by the checker of the UTF-8 to display code core.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef UTF8_TO_VFD_CODEPAGE_CORE_ASSERT_SVH
`define UTF8_TO_VFD_CODEPAGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define UVF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8_to_vfd_codepage_core: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define UVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8_to_vfd_codepage_core: assertion failed");

`endif

>>> rtl/utfvfd_pkg.sv
// Shared types, byte constants and code table of the UTF-8 to display code core.
// No dependencies.
package utfvfd_pkg;

    localparam int unsigned CFG_W   = 8;

    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_C3   = 2'd1;
    localparam logic [1:0] LEAD_C2   = 2'd2;

    localparam logic CFG_WIDE_MODULE  = 1'b0;
    localparam logic CFG_OUT_CAPACITY = 1'b1;

    localparam logic [7:0] CAPACITY_RESET = 8'd64;

    localparam logic [7:0] QMARK        = 8'h3F;
    localparam logic [7:0] BYTE_C3      = 8'hC3;
    localparam logic [7:0] BYTE_C2      = 8'hC2;
    localparam logic [7:0] BYTE_DEGREE  = 8'hB0;
    localparam logic [7:0] CODE_DEG_N   = 8'hEF;
    localparam logic [7:0] CODE_DEG_W   = 8'hB0;

    typedef struct packed {
        logic [1:0] pending_lead;
        logic [1:0] skip_left;
        logic [7:0] emitted_count;
    } state_t;

    typedef struct packed {
        logic       code_valid;
        logic [7:0] code_byte;
        logic       text_done;
        logic [7:0] code_count;
    } result_t;

    function automatic logic [7:0] umlaut_code(input logic [7:0] b2, input logic wide);
        logic [7:0] code;
        unique case (b2)
            8'h84:   code = wide ? 8'hC4 : 8'h8E;
            8'hA4:   code = wide ? 8'hE4 : 8'h84;
            8'h96:   code = wide ? 8'hD6 : 8'h99;
            8'hB6:   code = wide ? 8'hF6 : 8'h94;
            8'h9C:   code = wide ? 8'hDC : 8'h9A;
            8'hBC:   code = wide ? 8'hFC : 8'h81;
            default: code = QMARK;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/utfvfd_cfg_regs.sv
// Configuration registers: code table select and per-string output capacity.
// Depends on utfvfd_pkg.
module utfvfd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [utfvfd_pkg::CFG_W-1:0] cfg_data,
    output logic                         wide_module,
    output logic [7:0]                   out_capacity
);

    logic       wide_reg;
    logic       wide_next;
    logic [7:0] cap_reg;
    logic [7:0] cap_next;

    always_comb
    begin
        wide_next = wide_reg;
        cap_next  = cap_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                utfvfd_pkg::CFG_WIDE_MODULE:  wide_next = cfg_data[0];
                utfvfd_pkg::CFG_OUT_CAPACITY: cap_next  = cfg_data[7:0];
                default:                      wide_next = wide_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
            cap_reg  <= utfvfd_pkg::CAPACITY_RESET;
        end
        else
        begin
            wide_reg <= wide_next;
            cap_reg  <= cap_next;
        end
    end

    assign wide_module  = wide_reg;
    assign out_capacity = cap_reg;

endmodule

>>> rtl/utfvfd_decode.sv
// Single-pass decode of one source byte against the current string state.
// Depends on utfvfd_pkg.
module utfvfd_decode (
    input  logic [7:0]          in_byte,
    input  logic                end_of_text,
    input  logic                wide_module,
    input  logic [7:0]          out_capacity,
    input  utfvfd_pkg::state_t  st,
    output utfvfd_pkg::state_t  st_next,
    output utfvfd_pkg::result_t res
);

    logic       emit;
    logic       valid;
    logic [7:0] code;
    logic [1:0] pend;
    logic [1:0] skip;
    logic [7:0] count;

    always_comb
    begin
        emit = 1'b0;
        code = 8'd0;
        pend = st.pending_lead;
        skip = st.skip_left;
        if (st.skip_left != 2'd0)
        begin
            skip = st.skip_left - 2'd1;
        end
        else if (st.pending_lead == utfvfd_pkg::LEAD_C3)
        begin
            pend = utfvfd_pkg::LEAD_NONE;
            code = utfvfd_pkg::umlaut_code(in_byte, wide_module);
            emit = 1'b1;
        end
        else if (st.pending_lead == utfvfd_pkg::LEAD_C2)
        begin
            pend = utfvfd_pkg::LEAD_NONE;
            if (in_byte == utfvfd_pkg::BYTE_DEGREE)
                code = wide_module ? utfvfd_pkg::CODE_DEG_W : utfvfd_pkg::CODE_DEG_N;
            else
                code = utfvfd_pkg::QMARK;
            emit = 1'b1;
        end
        else if (!in_byte[7])
        begin
            code = in_byte;
            emit = 1'b1;
        end
        else if (in_byte == utfvfd_pkg::BYTE_C3 && !end_of_text)
        begin
            pend = utfvfd_pkg::LEAD_C3;
        end
        else if (in_byte == utfvfd_pkg::BYTE_C2 && !end_of_text)
        begin
            pend = utfvfd_pkg::LEAD_C2;
        end
        else
        begin
            code = utfvfd_pkg::QMARK;
            emit = 1'b1;
            if (in_byte[7:5] == 3'b110)
                skip = 2'd1;
            else if (in_byte[7:4] == 4'b1110)
                skip = 2'd2;
            else if (in_byte[7:3] == 5'b11110)
                skip = 2'd3;
            else
                skip = 2'd0;
        end

        valid = emit && (st.emitted_count < out_capacity);
        count = valid ? st.emitted_count + 8'd1 : st.emitted_count;

        res.code_valid = valid;
        res.code_byte  = valid ? code : 8'd0;
        res.text_done  = end_of_text;
        res.code_count = count;

        if (end_of_text)
        begin
            st_next.pending_lead  = utfvfd_pkg::LEAD_NONE;
            st_next.skip_left     = 2'd0;
            st_next.emitted_count = 8'd0;
        end
        else
        begin
            st_next.pending_lead  = pend;
            st_next.skip_left     = skip;
            st_next.emitted_count = count;
        end
    end

endmodule

>>> rtl/utf8_to_vfd_codepage_core.sv
// UTF-8 to display codepage translator, one source byte per item, one result per item.
// Path: input register, then result register, between input accept and result valid.
// Throughput: 1 item per cycle while the output is not stalled (m_axis_tready high).
// Reset (rst_n low, asynchronous): both stages empty, string state cleared,
// wide_module 0, out_capacity 64. Depends on utfvfd_pkg, utfvfd_cfg_regs, utfvfd_decode.
module utf8_to_vfd_codepage_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [utfvfd_pkg::CFG_W-1:0] cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
    input  logic                         s_axis_tlast,   // end_of_text
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [7:0] code_byte, [15:8] code_count
    output logic                         m_axis_tuser,   // code_valid
    output logic                         m_axis_tlast    // text_done
);

    logic                wide_module;
    logic [7:0]          out_capacity;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    utfvfd_pkg::result_t out_res_reg;
    utfvfd_pkg::result_t res;
    utfvfd_pkg::state_t  state_reg;
    utfvfd_pkg::state_t  state_next;
    logic                advance;
    logic                in_take;

    utfvfd_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .wide_module  (wide_module),
        .out_capacity (out_capacity)
    );

    utfvfd_decode u_dec (
        .in_byte      (in_byte_reg),
        .end_of_text  (in_last_reg),
        .wide_module  (wide_module),
        .out_capacity (out_capacity),
        .st           (state_reg),
        .st_next      (state_next),
        .res          (res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.code_count, out_res_reg.code_byte};
    assign m_axis_tuser  = out_res_reg.code_valid;
    assign m_axis_tlast  = out_res_reg.text_done;

endmodule

>>> rtl/utfvfd_checker.sv
// Port-level checker for utf8_to_vfd_codepage_core, bound to the top level.
// Depends on utf8_to_vfd_codepage_core_assert.svh.
`include "utf8_to_vfd_codepage_core_assert.svh"

module utfvfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic        out_stall;
    logic [17:0] out_word;
    logic [7:0]  out_code;
    logic [7:0]  out_count;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
    assign out_code  = m_axis_tdata[7:0];
    assign out_count = m_axis_tdata[15:8];

    `UVF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    `UVF_ASSERT_SAME(a_blank_code, clk, rst_n, m_axis_tvalid && !m_axis_tuser, out_code == 8'd0)
    `UVF_ASSERT_SAME(a_count_nonzero, clk, rst_n, m_axis_tvalid && m_axis_tuser, out_count != 8'd0)
    `UVF_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind utf8_to_vfd_codepage_core utfvfd_checker u_utfvfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
